[hw/rtl/assoc_lru_tag_cache_unit_macros.svh]
// Assertion macros shared by the checker of the tag cache unit.
`ifndef ASSOC_LRU_TAG_CACHE_UNIT_MACROS_SVH
`define ASSOC_LRU_TAG_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define ALRU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tag cache check failed");

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define ALRU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tag cache check failed");

`endif

[hw/rtl/alru_pkg.sv]
// Package with the word types, line record, codes and states of the tag cache unit.
package alru_pkg;

	localparam int KEY_W  = 64;
	localparam int LEN_W  = 17;
	localparam int LINE_W = 4;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} alru_op_t;

	typedef struct packed {
		alru_op_t         op;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] now;
		logic [LEN_W-1:0] obj_length;
	} alru_req_t;

	typedef struct packed {
		logic              hit;
		logic [LINE_W-1:0] line;
		logic [LEN_W-1:0]  stored_length;
	} alru_rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] stamp;
		logic [LEN_W-1:0] length;
	} alru_rec_t;

	localparam int REC_W = $bits(alru_rec_t);

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} alru_cmd_t;

	typedef struct packed {
		logic scan_last;
	} alru_sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} alru_state_t;

endpackage

[hw/rtl/alru_ram.sv]
// Generic single write port RAM with one registered read port.
module alru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/alru_ctrl.sv]
// Sequencer that steps the datapath through load, line scan, drain and commit.
module alru_ctrl import alru_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  alru_sts_t sts,
	output alru_cmd_t cmd,
	output logic      busy,
	output logic      done
);

	alru_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_FINISH: begin
				cmd.commit = 1'b1;
				done       = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

[hw/rtl/alru_dp.sv]
// Datapath with the line store, the scan counter, the match and victim search and the result.
module alru_dp import alru_pkg::*; #(
	parameter int NUM_LINES  = 16,
	parameter int MAX_OBJECT = 131072
) (
	input  logic      clk,
	input  logic      arst_n,
	input  alru_cmd_t cmd,
	input  alru_req_t req,
	output alru_sts_t sts,
	output alru_rsp_t rsp
);

	localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam int CMP_W = 21;
	localparam logic [CMP_W-1:0] MAX_LEN  = CMP_W'(MAX_OBJECT);
	localparam logic [LEN_W-1:0] SAT_LEN  = LEN_W'(MAX_OBJECT - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LINES - 1);

	logic [NUM_LINES-1:0] valid_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     idx_s1;
	logic                 rd_vld_s1;
	logic                 found_q;
	logic                 free_q;
	logic [IDX_W-1:0]     sel_q;
	logic [KEY_W-1:0]     best_q;
	logic [LEN_W-1:0]     len_q;
	alru_op_t             op_q;
	logic [KEY_W-1:0]     key_q;
	logic [KEY_W-1:0]     now_q;
	alru_rec_t            rd_rec;
	alru_rec_t            wr_rec;
	logic                 wr_en;
	logic [LEN_W-1:0]     len_sat;

	assign len_sat = (CMP_W'(req.obj_length) >= MAX_LEN) ? SAT_LEN : req.obj_length;

	assign wr_en  = cmd.commit && ((op_q == OP_INSERT) || found_q);
	assign wr_rec = '{key: key_q, stamp: now_q, length: len_q};

	alru_ram #(
		.WIDTH(REC_W),
		.DEPTH(NUM_LINES)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(sel_q),
		.wdata(wr_rec),
		.re   (cmd.scan),
		.raddr(idx_q),
		.rdata(rd_rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			free_q    <= 1'b0;
			op_q      <= OP_LOOKUP;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (cmd.load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
				op_q    <= req.op;
			end else if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rd_vld_s1) begin
				if (op_q == OP_LOOKUP) begin
					if (!found_q && valid_q[idx_s1] && (rd_rec.key == key_q)) begin
						found_q <= 1'b1;
					end
				end else if (!free_q && !valid_q[idx_s1]) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.commit && (op_q == OP_INSERT)) begin
				valid_q[sel_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (cmd.load) begin
			key_q <= req.key;
			now_q <= req.now;
			len_q <= len_sat;
			sel_q <= '0;
			best_q <= '0;
		end else if (rd_vld_s1) begin
			if (op_q == OP_LOOKUP) begin
				if (!found_q && valid_q[idx_s1] && (rd_rec.key == key_q)) begin
					sel_q <= idx_s1;
					len_q <= rd_rec.length;
				end
			end else if (!free_q) begin
				if (!valid_q[idx_s1]) begin
					sel_q <= idx_s1;
				end else if ((idx_s1 == '0) || (rd_rec.stamp < best_q)) begin
					sel_q  <= idx_s1;
					best_q <= rd_rec.stamp;
				end
			end
		end
	end

	assign sts.scan_last = (idx_q == LAST_IDX);

	assign rsp.hit           = found_q;
	assign rsp.line          = LINE_W'(sel_q);
	assign rsp.stored_length = found_q ? len_q : '0;

endmodule

[hw/rtl/assoc_lru_tag_cache_unit.sv]
// Top level of the fully associative tag cache with least recently used replacement.
//
//   Channel  | Handshake               | Word
//   request  | start high, busy low    | req : alru_req_t (op, key, now, obj_length)
//   result   | done high for one cycle | rsp : alru_rsp_t (hit, line, stored_length)
//
// A request goes through the scan, drain and finish states before the next one is accepted.
// The scan reads one line record per cycle from the single read port of the line store.
// The result is on rsp in the finish state while done is high, taken at the edge that
// updates the store.
// Reset clears every valid mark at once, so no clearing pass is needed.
// The result cannot be stalled; busy is low only in the idle state and high through the result cycle.
module assoc_lru_tag_cache_unit import alru_pkg::*; #(
	parameter int NUM_LINES  = 16,
	parameter int MAX_OBJECT = 131072
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  alru_req_t req,
	output logic      busy,
	output logic      done,
	output alru_rsp_t rsp
);

	alru_cmd_t cmd;
	alru_sts_t sts;

	alru_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	alru_dp #(
		.NUM_LINES (NUM_LINES),
		.MAX_OBJECT(MAX_OBJECT)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.req   (req),
		.sts   (sts),
		.rsp   (rsp)
	);

endmodule

[hw/rtl/alru_checker.sv]
// Port-level checker of the tag cache unit and its bind to the top level.
`include "assoc_lru_tag_cache_unit_macros.svh"

module alru_checker import alru_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input alru_rsp_t rsp
);

	`ALRU_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`ALRU_ASSERT_NOW(a_done_in_busy, done, busy)
	`ALRU_ASSERT_NEXT(a_done_frees, done, !busy && !done)
	`ALRU_ASSERT_NOW(a_miss_no_length, done && !rsp.hit, rsp.stored_length == '0)

endmodule

bind assoc_lru_tag_cache_unit alru_checker u_alru_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);

[verif/assoc_lru_tag_cache_unit_checker.sv]
// Checker that predicts every lookup and insert of the tag cache and compares each result word.
module assoc_lru_tag_cache_unit_checker import alru_pkg::*; #(
	parameter int NUM_LINES  = 16,
	parameter int MAX_OBJECT = 131072
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  alru_req_t req,
	input  logic      done,
	input  alru_rsp_t rsp,
	output int        errors,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic             tag_valid [NUM_LINES];
	logic [KEY_W-1:0] tag_key   [NUM_LINES];
	logic [KEY_W-1:0] tag_stamp [NUM_LINES];
	logic [LEN_W-1:0] tag_length[NUM_LINES];

	alru_rsp_t pending_rsp[$];
	int        err_cnt = 0;

	function automatic int pick_line_to_fill();
		int            best;
		logic [KEY_W-1:0] best_stamp;
		best = 0;
		best_stamp = tag_stamp[0];
		for (int i = 0; i < NUM_LINES; i++) begin
			if (!tag_valid[i])
				return i;
			if (tag_stamp[i] < best_stamp) begin
				best_stamp = tag_stamp[i];
				best = i;
			end
		end
		return best;
	endfunction

	function automatic alru_rsp_t cache_access(alru_req_t r);
		alru_rsp_t res;
		int        v;
		longint unsigned len;
		res = '0;
		if (r.op == OP_LOOKUP) begin
			for (int i = 0; i < NUM_LINES; i++) begin
				if (tag_valid[i] && tag_key[i] == r.key) begin
					tag_stamp[i] = r.now;
					res.hit = 1'b1;
					res.line = i[LINE_W-1:0];
					res.stored_length = tag_length[i];
					break;
				end
			end
		end else begin
			v = pick_line_to_fill();
			len = longint'(r.obj_length);
			if (len >= longint'(MAX_OBJECT))
				len = longint'(MAX_OBJECT - 1);
			tag_key[v] = r.key;
			tag_length[v] = len[LEN_W-1:0];
			tag_stamp[v] = r.now;
			tag_valid[v] = 1'b1;
			res.line = v[LINE_W-1:0];
		end
		return res;
	endfunction

	task automatic check_field(input string fname, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v !== got_v) begin
			err_cnt++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alru_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_LINES; i++) begin
				tag_valid[i] = 1'b0;
				tag_key[i] = '0;
				tag_stamp[i] = '0;
				tag_length[i] = '0;
			end
			pending_rsp.delete();
			errors <= err_cnt;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result word: expected none, actual hit=%0d line=%0d len=%0d",
						$time, rsp.hit, rsp.line, rsp.stored_length);
				end else begin
					want = pending_rsp.pop_front();
					check_field("hit", want.hit, rsp.hit);
					check_field("line", want.line, rsp.line);
					check_field("stored_length", want.stored_length, rsp.stored_length);
				end
			end
			if (start && !busy)
				pending_rsp.push_back(cache_access(req));
			errors <= err_cnt;
			outstanding <= pending_rsp.size();
		end
	end

endmodule

[verif/assoc_lru_tag_cache_unit_tb.sv]
// Testbench top that drives lookup and insert words into the tag cache and gives the verdict.
module assoc_lru_tag_cache_unit_tb import alru_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINES       = 16;
	localparam int MAX_OBJ     = 131072;
	localparam int RAND_ITEMS  = 700;
	localparam int CALM_ITEMS  = 100;
	localparam int KEY_POOL    = 24;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	alru_req_t req = '0;
	logic      busy;
	logic      done;
	alru_rsp_t rsp;
	int        errors;
	int        outstanding;
	int        cycles = 0;

	logic [KEY_W-1:0] key_pool[KEY_POOL];
	logic [KEY_W-1:0] clock_now = '0;

	assoc_lru_tag_cache_unit #(
		.NUM_LINES(LINES),
		.MAX_OBJECT(MAX_OBJ)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	assoc_lru_tag_cache_unit_checker #(
		.NUM_LINES(LINES),
		.MAX_OBJECT(MAX_OBJ)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.errors(errors),
		.outstanding(outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("assoc_lru_tag_cache_unit_tb: FAIL");
			$finish;
		end
	end

	// The gap starts once the block is ready again, so its idle cycles fall while the block is idle.
	task automatic send_word(input alru_req_t w, input int gap);
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			do @(posedge clk); while (busy);
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic alru_req_t make_word(alru_op_t op, logic [KEY_W-1:0] k,
			logic [KEY_W-1:0] t, logic [LEN_W-1:0] len);
		alru_req_t w;
		w.op = op;
		w.key = k;
		w.now = t;
		w.obj_length = len;
		return w;
	endfunction

	function automatic logic [KEY_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [KEY_W-1:0] pick_time();
		case ($urandom_range(0, 3))
			0: begin
				clock_now = clock_now + $urandom_range(1, 5);
				return clock_now;
			end
			1: return rand64();
			2: return KEY_W'($urandom_range(0, 3));
			default: return ALL_ONES - KEY_W'($urandom_range(0, 2));
		endcase
	endfunction

	task automatic refill_pool();
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = rand64();
		key_pool[0] = '0;
		key_pool[1] = ALL_ONES;
	endtask

	initial begin
		alru_op_t         op;
		logic [KEY_W-1:0] k;
		int               gap;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A cleared line must not match key zero; duplicates resolve to the lowest line.
		send_word(make_word(OP_LOOKUP, '0, '0, '1), 0);
		send_word(make_word(OP_INSERT, ALL_ONES, ALL_ONES, '1), 0);
		send_word(make_word(OP_INSERT, ALL_ONES, ALL_ONES, '0), 3);
		send_word(make_word(OP_LOOKUP, ALL_ONES, ALL_ONES, '0), 0);
		for (int i = 2; i < LINES; i++)
			send_word(make_word(OP_INSERT, KEY_W'(i), ALL_ONES,
				LEN_W'($urandom_range(0, MAX_OBJ - 1))), i % 3);
		// Every line valid with all-ones stamps, so the victim is line zero.
		send_word(make_word(OP_INSERT, '0, '0, LEN_W'(1)), 0);
		send_word(make_word(OP_LOOKUP, ALL_ONES, KEY_W'(9), '1), 0);
		send_word(make_word(OP_LOOKUP, '0, KEY_W'(5), '0), 1);
		send_word(make_word(OP_INSERT, KEY_W'(100), KEY_W'(7), '1), 0);
		send_word(make_word(OP_LOOKUP, KEY_W'(3), '0, '0), 0);

		refill_pool();
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 100 == 99)
				refill_pool();
			op = ($urandom_range(0, 1) == 0) ? OP_LOOKUP : OP_INSERT;
			if ($urandom_range(0, 7) == 0)
				k = rand64();
			else
				k = key_pool[$urandom_range(0, KEY_POOL - 1)];
			gap = 0;
			if (n < RAND_ITEMS - CALM_ITEMS && $urandom_range(0, 2) == 0)
				gap = $urandom_range(1, 8);
			send_word(make_word(op, k, pick_time(), LEN_W'($urandom())), gap);
		end
		start <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (LINES + 4) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("assoc_lru_tag_cache_unit_tb: PASS");
		else
			$display("assoc_lru_tag_cache_unit_tb: FAIL");
		$finish;
	end

endmodule
